### design/stm_pkg.sv
`default_nettype none

package stm_pkg;

	localparam int DEF_MAX_B_ENTRIES = 64;
	localparam int DEF_INDEX_BITS    = 8;
	localparam int DEF_VALUE_BITS    = 16;
	localparam int PRODUCT_BITS      = 32;

	typedef enum logic [1:0] {
		ACT_CLEAR   = 2'd0,
		ACT_APPEND  = 2'd1,
		ACT_PRESENT = 2'd2
	} action_t;

	// Per-cell control: load a new B triplet, or take the neighbour's entry.
	typedef struct packed {
		logic load;
		logic shift;
	} cell_ctrl_t;

	// Compare-stage flags handed to the product stage.
	typedef struct packed {
		logic hit;
		logic pass_end;
	} scan_ctrl_t;

endpackage

`default_nettype wire

### design/stm_cell.sv
`default_nettype none

module stm_cell #(
	parameter int IDX_W = 8,
	parameter int VAL_W = 16
) (
	input  wire                    clk,
	input  stm_pkg::cell_ctrl_t    ctrl,
	input  wire  [IDX_W-1:0]       load_row,
	input  wire  [IDX_W-1:0]       load_col,
	input  wire  [VAL_W-1:0]       load_value,
	input  wire  [IDX_W-1:0]       next_row,
	input  wire  [IDX_W-1:0]       next_col,
	input  wire  [VAL_W-1:0]       next_value,
	output logic [IDX_W-1:0]       row,
	output logic [IDX_W-1:0]       col,
	output logic [VAL_W-1:0]       value
);
	import stm_pkg::*;

	logic [IDX_W-1:0] row_q;
	logic [IDX_W-1:0] col_q;
	logic [VAL_W-1:0] value_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			row_q   <= load_row;
			col_q   <= load_col;
			value_q <= load_value;
		end else if (ctrl.shift) begin
			row_q   <= next_row;
			col_q   <= next_col;
			value_q <= next_value;
		end
	end

	assign row   = row_q;
	assign col   = col_q;
	assign value = value_q;

endmodule

`default_nettype wire

### design/stm_product.sv
`default_nettype none

module stm_product #(
	parameter int IDX_W = 8,
	parameter int VAL_W = 16
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  stm_pkg::scan_ctrl_t               ctrl_s1,
	input  wire  [IDX_W-1:0]                  b_col_s1,
	input  wire  signed [VAL_W-1:0]           b_value_s1,
	input  wire  [IDX_W-1:0]                  a_row,
	input  wire  signed [VAL_W-1:0]           a_value,
	output logic                              pass_done,
	output logic                              result_valid,
	output logic [IDX_W-1:0]                  out_row,
	output logic [IDX_W-1:0]                  out_col,
	output logic signed [stm_pkg::PRODUCT_BITS-1:0] product,
	output logic                              last
);
	import stm_pkg::*;

	logic signed [PRODUCT_BITS-1:0] a_ext;
	logic signed [PRODUCT_BITS-1:0] b_ext;

	logic                           hit_s2;
	logic                           end_s2;
	logic [IDX_W-1:0]               col_s2;
	logic signed [PRODUCT_BITS-1:0] prod_s2;
	logic                           end_s3;

	logic                           pend_valid_q;
	logic [IDX_W-1:0]               pend_col_q;
	logic signed [PRODUCT_BITS-1:0] pend_prod_q;

	logic                           valid_q;
	logic                           last_q;
	logic [IDX_W-1:0]               row_q;
	logic [IDX_W-1:0]               col_q;
	logic signed [PRODUCT_BITS-1:0] prod_q;

	logic emit_mid;
	logic emit_last;

	// Only the low product bits are kept, so sign-extended operands suffice.
	assign a_ext = PRODUCT_BITS'(a_value);
	assign b_ext = PRODUCT_BITS'(b_value_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_s2 <= 1'b0;
			end_s2 <= 1'b0;
			end_s3 <= 1'b0;
		end else begin
			hit_s2 <= ctrl_s1.hit;
			end_s2 <= ctrl_s1.pass_end;
			end_s3 <= end_s2;
		end
	end

	always_ff @(posedge clk) begin
		col_s2  <= b_col_s1;
		prod_s2 <= a_ext * b_ext;
	end

	// A match is held until the next match or pass end, so the final one carries last.
	assign emit_mid  = hit_s2 && pend_valid_q;
	assign emit_last = end_s3 && pend_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			valid_q      <= 1'b0;
			last_q       <= 1'b0;
		end else begin
			if (hit_s2) begin
				pend_valid_q <= 1'b1;
			end else if (end_s3) begin
				pend_valid_q <= 1'b0;
			end
			valid_q <= emit_mid || emit_last;
			last_q  <= emit_last;
		end
	end

	always_ff @(posedge clk) begin
		if (hit_s2) begin
			pend_col_q  <= col_s2;
			pend_prod_q <= prod_s2;
		end
		if (emit_mid || emit_last) begin
			row_q  <= a_row;
			col_q  <= pend_col_q;
			prod_q <= pend_prod_q;
		end
	end

	assign pass_done    = end_s3;
	assign result_valid = valid_q;
	assign out_row      = row_q;
	assign out_col      = col_q;
	assign product      = prod_q;
	assign last         = last_q;

endmodule

`default_nettype wire

### design/sparse_triplet_multiply_unit.sv
// Channel   Ports                                           Handshake
// command   action, row_index, col_index, entry_value       start high while busy low
// result    out_row, out_col, product, last                 result_valid, one cycle each
//
// Clear, append, unused and zero-valued present beats leave busy low.
// A present beat with a nonzero value rotates the B ring once round, one entry per
// cycle, and busy stays high until the pass is done, however few entries are filled.
// Results leave at most one per cycle and cannot be stalled by the receiver.
// Reset empties the store; the ring contents are only read below the fill count.
`default_nettype none

module sparse_triplet_multiply_unit #(
	parameter int MAX_B_ENTRIES = stm_pkg::DEF_MAX_B_ENTRIES,
	parameter int INDEX_BITS    = stm_pkg::DEF_INDEX_BITS,
	parameter int VALUE_BITS    = stm_pkg::DEF_VALUE_BITS
) (
	input  wire                                     clk,
	input  wire                                     arst_n,
	input  wire                                     start,
	output logic                                    busy,
	input  wire  [1:0]                              action,
	input  wire  [INDEX_BITS-1:0]                   row_index,
	input  wire  [INDEX_BITS-1:0]                   col_index,
	input  wire  signed [VALUE_BITS-1:0]            entry_value,
	output logic                                    result_valid,
	output logic [INDEX_BITS-1:0]                   out_row,
	output logic [INDEX_BITS-1:0]                   out_col,
	output logic signed [stm_pkg::PRODUCT_BITS-1:0] product,
	output logic                                    last
);
	import stm_pkg::*;

	localparam int CNT_W = $clog2(MAX_B_ENTRIES + 1);
	localparam int K_W   = (MAX_B_ENTRIES > 1) ? $clog2(MAX_B_ENTRIES) : 1;

	logic                         accept;
	logic                         do_append;
	logic                         do_clear;
	logic                         do_present;

	logic                         busy_q;
	logic                         scanning_q;
	logic [K_W-1:0]               scan_k_q;
	logic [CNT_W-1:0]             b_count_q;
	logic [INDEX_BITS-1:0]        a_row_q;
	logic [INDEX_BITS-1:0]        a_col_q;
	logic signed [VALUE_BITS-1:0] a_value_q;

	logic [INDEX_BITS-1:0]        cell_row   [MAX_B_ENTRIES];
	logic [INDEX_BITS-1:0]        cell_col   [MAX_B_ENTRIES];
	logic [VALUE_BITS-1:0]        cell_value [MAX_B_ENTRIES];

	scan_ctrl_t                   ctrl_s1;
	logic [INDEX_BITS-1:0]        b_col_s1;
	logic signed [VALUE_BITS-1:0] b_value_s1;
	logic                         scan_last;
	logic                         pass_done;

	assign accept = start && !busy_q;

	always_comb begin
		do_clear   = 1'b0;
		do_append  = 1'b0;
		do_present = 1'b0;
		if (accept) begin
			case (action_t'(action))
				ACT_CLEAR:   do_clear = 1'b1;
				ACT_APPEND:  do_append = (entry_value != '0) &&
				                         (b_count_q < CNT_W'(MAX_B_ENTRIES));
				ACT_PRESENT: do_present = (entry_value != '0);
				default:     do_clear = 1'b0;
			endcase
		end
	end

	assign scan_last = (scan_k_q == K_W'(MAX_B_ENTRIES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			scanning_q <= 1'b0;
			scan_k_q   <= '0;
			b_count_q  <= '0;
		end else begin
			if (do_clear) begin
				b_count_q <= '0;
			end else if (do_append) begin
				b_count_q <= b_count_q + 1'b1;
			end
			if (do_present) begin
				busy_q     <= 1'b1;
				scanning_q <= 1'b1;
			end else if (pass_done) begin
				busy_q <= 1'b0;
			end
			if (scanning_q) begin
				if (scan_last) begin
					scanning_q <= 1'b0;
					scan_k_q   <= '0;
				end else begin
					scan_k_q <= scan_k_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_present) begin
			a_row_q   <= row_index;
			a_col_q   <= col_index;
			a_value_q <= entry_value;
		end
	end

	// The ring turns once per pass, bringing each entry to cell zero in load order
	// and leaving every entry back in its own cell at the end.
	for (genvar i = 0; i < MAX_B_ENTRIES; i++) begin : g_cell
		localparam int NXT = (i + 1) % MAX_B_ENTRIES;
		cell_ctrl_t ctrl;

		assign ctrl.load  = do_append && (b_count_q == CNT_W'(i));
		assign ctrl.shift = scanning_q;

		stm_cell #(
			.IDX_W (INDEX_BITS),
			.VAL_W (VALUE_BITS)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.load_row   (row_index),
			.load_col   (col_index),
			.load_value (entry_value),
			.next_row   (cell_row[NXT]),
			.next_col   (cell_col[NXT]),
			.next_value (cell_value[NXT]),
			.row        (cell_row[i]),
			.col        (cell_col[i]),
			.value      (cell_value[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else begin
			ctrl_s1.hit      <= scanning_q && (CNT_W'(scan_k_q) < b_count_q) &&
			                    (cell_row[0] == a_col_q);
			ctrl_s1.pass_end <= scanning_q && scan_last;
		end
	end

	always_ff @(posedge clk) begin
		b_col_s1   <= cell_col[0];
		b_value_s1 <= cell_value[0];
	end

	stm_product #(
		.IDX_W (INDEX_BITS),
		.VAL_W (VALUE_BITS)
	) u_product (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl_s1      (ctrl_s1),
		.b_col_s1     (b_col_s1),
		.b_value_s1   (b_value_s1),
		.a_row        (a_row_q),
		.a_value      (a_value_q),
		.pass_done    (pass_done),
		.result_valid (result_valid),
		.out_row      (out_row),
		.out_col      (out_col),
		.product      (product),
		.last         (last)
	);

	assign busy = busy_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		b_count_q <= CNT_W'(MAX_B_ENTRIES))
		else $error("B fill count exceeds store depth");

	a_scan_in_pass: assert property (@(posedge clk) disable iff (!arst_n)
		scanning_q |-> busy_q)
		else $error("ring rotating outside a pass");

	a_idle_index: assert property (@(posedge clk) disable iff (!arst_n)
		!scanning_q |-> (scan_k_q == '0))
		else $error("scan index not parked between passes");

	a_done_in_pass: assert property (@(posedge clk) disable iff (!arst_n)
		pass_done |-> (busy_q && !scanning_q))
		else $error("pass completion outside a pass");

	a_store_stable: assert property (@(posedge clk) disable iff (!arst_n)
		scanning_q |=> $stable(b_count_q))
		else $error("fill count changed during a pass");

endmodule

`default_nettype wire
